FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lrupfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page frame manager package
// Field widths, the empty-page marker and the controller state type.
// ----------------------------------------------------------------------------
package lrupfm_pkg;

  localparam int PAGE_W      = 16;
  localparam int FRAME_NUM_W = 4;

  // A frame holding this value is empty; a request for it never hits.
  localparam logic [PAGE_W-1:0] EMPTY_PAGE = 16'hFFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lrupfm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one virtual page index per item.
// ----------------------------------------------------------------------------
interface lrupfm_req_if;
  logic                          valid;
  logic                          ready;
  logic [lrupfm_pkg::PAGE_W-1:0] page_index;

  modport source (output valid, output page_index, input ready);
  modport sink   (input valid, input page_index, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lrupfm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the frame assignment for one request.
// ----------------------------------------------------------------------------
interface lrupfm_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [lrupfm_pkg::FRAME_NUM_W-1:0] frame_number;
  logic                               hit;
  logic                               write_back;
  logic [lrupfm_pkg::PAGE_W-1:0]      evicted_page;

  modport source (output valid, output frame_number, output hit, output write_back,
                  output evicted_page, input ready);
  modport sink   (input valid, input frame_number, input hit, input write_back,
                  input evicted_page, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lru_page_frame_manager_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page frame manager
// Maps virtual pages onto physical frames with least-recently-used eviction.
// ----------------------------------------------------------------------------
// After acceptance each request runs a single pass over the use-order memory,
// one entry per cycle, which searches for the page and closes the gap left by
// a hit frame in the same pass; once the output register is free the response
// is written to it and the next request can be accepted. The use order is a
// circular list, so a miss only advances its head pointer. Both memories come
// out of reset through per-entry valid bits, so no clearing pass is needed and
// the block is ready in the cycle after reset. The response sits in an output
// register, and a new request is taken while an earlier response still waits
// to be collected.
`include "assert_macros.svh"

module lru_page_frame_manager_unit #(
  parameter int FRAME_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  lrupfm_req_if.sink    req,
  lrupfm_rsp_if.source  rsp
);

  localparam int FW = $clog2(FRAME_COUNT);
  localparam int CW = $clog2(FRAME_COUNT + 1);
  localparam int PW = lrupfm_pkg::PAGE_W;
  localparam int NW = lrupfm_pkg::FRAME_NUM_W;

  localparam logic [CW-1:0] FULL_CNT  = CW'(FRAME_COUNT);
  localparam logic [CW-1:0] LAST_CNT  = CW'(FRAME_COUNT - 1);
  localparam logic [FW-1:0] LAST_SLOT = FW'(FRAME_COUNT - 1);

  lrupfm_pkg::state_t state, state_next;

  logic [PW-1:0] page;
  logic [FW-1:0] head;
  logic [CW-1:0] rd_cnt;
  logic [FW-1:0] rd_slot;

  logic          b_vld, b_first, b_last;
  logic [FW-1:0] b_slot;
  logic          c_vld, c_first, c_last;
  logic [FW-1:0] c_slot, c_frame;

  logic          found;
  logic [FW-1:0] hit_frame, lru_frame, prev_slot;
  logic [PW-1:0] lru_page;

  logic [FW-1:0]    uo_mem [FRAME_COUNT];
  logic [PW-1:0]    fp_mem [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] uo_valid, fp_valid;
  logic [FW-1:0]    uo_q;
  logic             uo_q_vld;
  logic [PW-1:0]    fp_q;
  logic             fp_q_vld;

  logic          out_valid, out_hit, out_wb;
  logic [NW-1:0] out_frame;
  logic [PW-1:0] out_evict;

  logic          accept, rd_issue, fin_go;
  logic [FW-1:0] b_frame;
  logic [PW-1:0] c_page;
  logic          c_match;
  logic          uo_we, fp_we;
  logic [FW-1:0] uo_waddr, uo_wdata;
  logic [FW-1:0] fin_frame;
  logic [FW+NW-1:0] fin_frame_ext;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rd_issue   = 1'b0;
    fin_go     = 1'b0;
    case (state)
      lrupfm_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = lrupfm_pkg::S_SCAN;
        end
      end
      lrupfm_pkg::S_SCAN: begin
        rd_issue = (rd_cnt != FULL_CNT);
        if (c_vld && c_last) begin
          state_next = lrupfm_pkg::S_FINISH;
        end
      end
      lrupfm_pkg::S_FINISH: begin
        fin_go = !out_valid || rsp.ready;
        if (fin_go) begin
          state_next = lrupfm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lrupfm_pkg::S_IDLE;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  // An entry that has never been written reads as its reset value.
  assign b_frame = uo_q_vld ? uo_q : b_slot;
  assign c_page  = fp_q_vld ? fp_q : lrupfm_pkg::EMPTY_PAGE;
  assign c_match = c_vld && (page != lrupfm_pkg::EMPTY_PAGE) && (c_page == page);

  // Once the hit frame has been passed, every later entry moves one place
  // towards the head; at the end the hit frame goes into the last place.
  always_comb begin
    uo_we    = 1'b0;
    uo_waddr = prev_slot;
    uo_wdata = c_frame;
    if (c_vld && found) begin
      uo_we = 1'b1;
    end else if (fin_go && found) begin
      uo_we    = 1'b1;
      uo_wdata = hit_frame;
    end
  end

  assign fp_we         = fin_go && !found;
  assign fin_frame     = found ? hit_frame : lru_frame;
  assign fin_frame_ext = {{NW{1'b0}}, fin_frame};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrupfm_pkg::S_IDLE;
      head      <= '0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      uo_valid  <= '0;
      fp_valid  <= '0;
    end else begin
      state <= state_next;
      b_vld <= rd_issue;
      c_vld <= b_vld;
      if (accept) begin
        found <= 1'b0;
      end else if (c_match) begin
        found <= 1'b1;
      end
      // A miss reuses the head frame, which then becomes the most recent.
      if (fp_we) begin
        head <= (head == LAST_SLOT) ? '0 : head + 1'b1;
      end
      if (uo_we) begin
        uo_valid[uo_waddr] <= 1'b1;
      end
      if (fp_we) begin
        fp_valid[lru_frame] <= 1'b1;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scan pipeline: read use order, read frame page, compare
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      page    <= req.page_index;
      rd_cnt  <= '0;
      rd_slot <= head;
    end else if (rd_issue) begin
      rd_cnt  <= rd_cnt + 1'b1;
      rd_slot <= (rd_slot == LAST_SLOT) ? '0 : rd_slot + 1'b1;
    end

    b_slot  <= rd_slot;
    b_first <= (rd_cnt == '0);
    b_last  <= (rd_cnt == LAST_CNT);

    c_slot  <= b_slot;
    c_frame <= b_frame;
    c_first <= b_first;
    c_last  <= b_last;

    if (c_vld) begin
      if (c_first) begin
        lru_frame <= c_frame;
        lru_page  <= c_page;
      end
      if (c_match) begin
        hit_frame <= c_frame;
      end
      prev_slot <= c_slot;
    end

    if (fin_go) begin
      out_frame <= fin_frame_ext[NW-1:0];
      out_hit   <= found;
      out_wb    <= !found && (lru_page != lrupfm_pkg::EMPTY_PAGE);
      out_evict <= found ? lrupfm_pkg::EMPTY_PAGE : lru_page;
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (uo_we) begin
      uo_mem[uo_waddr] <= uo_wdata;
    end
    uo_q     <= uo_mem[rd_slot];
    uo_q_vld <= uo_valid[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (fp_we) begin
      fp_mem[lru_frame] <= page;
    end
    fp_q     <= fp_mem[b_frame];
    fp_q_vld <= fp_valid[b_frame];
  end

  assign rsp.valid        = out_valid;
  assign rsp.frame_number = out_frame;
  assign rsp.hit          = out_hit;
  assign rsp.write_back   = out_wb;
  assign rsp.evicted_page = out_evict;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_hit_no_evict, rsp.valid && rsp.hit,
                  !rsp.write_back && (rsp.evicted_page == lrupfm_pkg::EMPTY_PAGE),
                  "a hit item reports an eviction")
  `ASSERT_IMPLIES(a_wb_has_page, rsp.valid && rsp.write_back,
                  rsp.evicted_page != lrupfm_pkg::EMPTY_PAGE,
                  "write-back flagged for an empty frame")
  `ASSERT_NEXT(a_scan_ends, c_vld && c_last && (state == lrupfm_pkg::S_SCAN),
               state == lrupfm_pkg::S_FINISH,
               "scan did not close after the last use-order entry")
  `ASSERT_IMPLIES(a_head_moves_on_miss, head != $past(head),
                  $past(state == lrupfm_pkg::S_FINISH) && !$past(found),
                  "use-order head moved outside a miss")

endmodule
`default_nettype wire
